>>> hdl/assert_macros.svh
// Assertion macros shared by the page table engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FPTE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPTE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FPTE_ASSERT(label, clk, rst_n, prop, msg)
`define FPTE_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

>>> hdl/fpte_pkg.sv
// Types, codes and constants of the four-level page table engine.
package fpte_pkg;

  localparam int unsigned TABLE_FRAMES      = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned FRAME_W           = 40;
  localparam int unsigned VPAGE_W           = 36;
  localparam int unsigned ATTR_W            = 12;
  localparam int unsigned ENTRY_W           = 64;

  localparam logic [ATTR_W-1:0] PTR_FLAGS = 12'h00F;

  localparam logic [1:0] CMD_MAP    = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_UNMAP  = 2'd2;
  localparam logic [1:0] CMD_REMAP  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_NOPATH  = 2'd2;
  localparam logic [1:0] ST_NOFRAME = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [VPAGE_W-1:0] virtual_page;
    logic [FRAME_W-1:0] target_frame;
    logic [ATTR_W-1:0]  attribute_bits;
    logic               no_execute;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ENTRY_W-1:0] entry_value;
    logic               tlb_invalidate;
  } res_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ENTRY_W-1:0] value;
    logic               wr;
    logic               inv;
  } leaf_res_t;

endpackage

>>> hdl/fpte_leaf.sv
// Leaf entry update for map, lookup, unmap and remap requests.
module fpte_leaf
  import fpte_pkg::*;
(
  input  req_t               req_i,
  input  logic [ENTRY_W-1:0] old_i,
  output leaf_res_t          res_o
);

  always_comb begin
    res_o.status = ST_DONE;
    res_o.value  = old_i;
    res_o.wr     = 1'b0;
    res_o.inv    = 1'b0;
    case (req_i.command)
      CMD_MAP: begin
        if (old_i[0]) begin
          res_o.status = ST_PRESENT;
        end else begin
          // The new leaf is written even when its present bit is clear.
          res_o.value = {req_i.no_execute, 11'b0, req_i.target_frame, req_i.attribute_bits};
          res_o.wr    = 1'b1;
          res_o.inv   = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        res_o.status = ST_DONE;
      end
      CMD_UNMAP: begin
        if (old_i[0]) begin
          res_o.value = {old_i[ENTRY_W-1:1], 1'b0};
          res_o.wr    = 1'b1;
          res_o.inv   = 1'b1;
        end
      end
      CMD_REMAP: begin
        if (old_i != '0) begin
          res_o.value = {old_i[ENTRY_W-1:1], 1'b1};
          res_o.wr    = 1'b1;
          res_o.inv   = 1'b1;
        end
      end
      default: begin
        res_o.status = ST_DONE;
      end
    endcase
  end

endmodule

>>> hdl/four_level_page_table_engine.sv
// Top level of the four-level page table engine with its table store.
// A request walks the tables level by level; the result strobe comes after the leaf update,
// and a new request can be taken in that same cycle. Failures end the walk early.
// The pace is set by one table store port with a registered read, read once per level.
// After reset the store is cleared one entry a cycle while busy stays high;
// the configuration register can be written at any time.
`include "assert_macros.svh"

module four_level_page_table_engine
  import fpte_pkg::*;
#(
  parameter int unsigned TableFrames = TABLE_FRAMES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               req_i,
  output logic               done_o,
  output res_t               result_o,
  input  logic               cfg_we_i,
  input  logic [FRAME_W-1:0] cfg_data_i
);

  localparam int unsigned Depth = TableFrames * ENTRIES_PER_TABLE;
  localparam int unsigned FW    = $clog2(TableFrames);
  localparam int unsigned AW    = FW + IDX_W;
  localparam int unsigned NW    = $clog2(TableFrames + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_FOLLOW = 3'd3;
  localparam logic [2:0] S_LEAF   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [1:0]         lvl_q, lvl_d;
  req_t               req_q, req_d;
  logic [ENTRY_W-1:0] entry_q, entry_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [NW-1:0]      nft_q, nft_d;
  logic [FRAME_W-1:0] base_q;
  logic [AW-1:0]      clr_q, clr_d;
  logic               done_q, done_d;
  res_t               res_q, res_d;

  logic [ENTRY_W-1:0] mem_q [Depth];
  logic [ENTRY_W-1:0] rdata_q;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_raddr, mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [FRAME_W:0]   diff;
  logic               ptr_ok;
  logic [FRAME_W-1:0] new_frame;
  leaf_res_t          leaf_res;

  function automatic logic [IDX_W-1:0] idx_of(logic [VPAGE_W-1:0] vp, logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd3:    idx = vp[35:27];
      2'd2:    idx = vp[26:18];
      2'd1:    idx = vp[17:9];
      default: idx = vp[8:0];
    endcase
    return idx;
  endfunction

  fpte_leaf u_leaf (
    .req_i (req_q),
    .old_i (rdata_q),
    .res_o (leaf_res)
  );

  // A present pointer must land inside the store, counted from the base frame.
  assign diff      = {1'b0, entry_q[51:12]} - {1'b0, base_q};
  assign ptr_ok    = !diff[FRAME_W] && (diff[FRAME_W-1:0] < FRAME_W'(TableFrames));
  assign new_frame = base_q + FRAME_W'(nft_q);

  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    req_d     = req_q;
    entry_d   = entry_q;
    addr_d    = addr_q;
    nft_d     = nft_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d     = req_i;
          lvl_d     = 2'd3;
          mem_re    = 1'b1;
          mem_raddr = {FW'(0), idx_of(req_i.virtual_page, 2'd3)};
          addr_d    = mem_raddr;
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (rdata_q[0]) begin
          entry_d = rdata_q;
          state_d = S_FOLLOW;
        end else if (req_q.command != CMD_MAP) begin
          done_d  = 1'b1;
          res_d   = '{status: ST_NOPATH, entry_value: '0, tlb_invalidate: 1'b0};
          state_d = S_IDLE;
        end else if (nft_q >= NW'(TableFrames)) begin
          done_d  = 1'b1;
          res_d   = '{status: ST_NOFRAME, entry_value: '0, tlb_invalidate: 1'b0};
          state_d = S_IDLE;
        end else begin
          // Take a fresh table frame from the pool and link it in.
          entry_d   = {12'h000, new_frame, PTR_FLAGS};
          mem_we    = 1'b1;
          mem_wdata = entry_d;
          nft_d     = nft_q + NW'(1);
          state_d   = S_FOLLOW;
        end
      end
      S_FOLLOW: begin
        if (!ptr_ok) begin
          done_d  = 1'b1;
          res_d   = '{status: ST_NOPATH, entry_value: '0, tlb_invalidate: 1'b0};
          state_d = S_IDLE;
        end else begin
          lvl_d     = lvl_q - 2'd1;
          mem_re    = 1'b1;
          mem_raddr = {diff[FW-1:0], idx_of(req_q.virtual_page, lvl_d)};
          addr_d    = mem_raddr;
          state_d   = (lvl_d == 2'd0) ? S_LEAF : S_EVAL;
        end
      end
      S_LEAF: begin
        mem_we    = leaf_res.wr;
        mem_wdata = leaf_res.value;
        done_d    = 1'b1;
        res_d     = '{status: leaf_res.status, entry_value: leaf_res.value,
                      tlb_invalidate: leaf_res.inv};
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Reads and writes never target the same entry in one cycle: the walk is strictly ordered.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      lvl_q   <= 2'd3;
      nft_q   <= NW'(1);
      base_q  <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      nft_q   <= nft_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    entry_q <= entry_d;
    addr_q  <= addr_d;
    res_q   <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `FPTE_ASSERT(a_done_after_work, clk_i, rst_ni, done_o |-> ($past(state_q) == S_EVAL || $past(state_q) == S_FOLLOW || $past(state_q) == S_LEAF), "result strobe without a walk in progress")
  `FPTE_ASSERT(a_pool_bound, clk_i, rst_ni, nft_q <= NW'(TableFrames), "table frame pool counter beyond the store")
  `FPTE_ASSERT_NEVER(a_no_stray_write, clk_i, rst_ni, mem_we && (state_q == S_IDLE || state_q == S_FOLLOW), "table store written outside clear, create or leaf update")
  `FPTE_ASSERT(a_inv_means_done, clk_i, rst_ni, (done_o && result_o.tlb_invalidate) |-> (result_o.status == ST_DONE), "invalidate flagged on a failed request")

endmodule

>>> tb/four_level_page_table_engine_tb.sv
// Self-checking testbench of the four-level page table engine.
module four_level_page_table_engine_tb;
  import fpte_pkg::*;

  localparam int STALL_LIMIT = 100000;
  localparam int SLOT_W      = $clog2(TABLE_FRAMES * ENTRIES_PER_TABLE);

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  req_t               req_i = '0;
  logic               done_o;
  res_t               result_o;
  logic               cfg_we_i = 1'b0;
  logic [FRAME_W-1:0] cfg_data_i = '0;

  // Shadow copy of the table store, the frame pool and the base register.
  logic [ENTRY_W-1:0] shadow_store [TABLE_FRAMES*ENTRIES_PER_TABLE];
  int unsigned        shadow_next_table = 1;
  logic [FRAME_W-1:0] shadow_base_frame = '0;

  res_t        pending_results [$];
  res_t        oldest_result;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  logic [IDX_W-1:0] ws_top [2];
  logic [IDX_W-1:0] ws_sec [2];
  logic [IDX_W-1:0] ws_thr [2];

  four_level_page_table_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t make_req(input logic [1:0] cmd, input logic [VPAGE_W-1:0] vp,
                                    input logic [FRAME_W-1:0] frame,
                                    input logic [ATTR_W-1:0] attr, input logic nx);
    req_t r;
    r.command        = cmd;
    r.virtual_page   = vp;
    r.target_frame   = frame;
    r.attribute_bits = attr;
    r.no_execute     = nx;
    return r;
  endfunction

  // Walks the shadow tables down to the leaf table, allocating missing tables on a map.
  function automatic logic [1:0] walk_shadow_tables(input logic [VPAGE_W-1:0] vp,
                                                    input bit make,
                                                    output logic [SLOT_W-1:0] leaf);
    int unsigned        frame_no;
    int unsigned        idx;
    logic [SLOT_W-1:0]  slot_no;
    logic [ENTRY_W-1:0] entry;
    logic [FRAME_W-1:0] ptr_frame;
    logic [FRAME_W-1:0] offset;
    frame_no = 0;
    leaf = '0;
    for (int lvl = 3; lvl >= 1; lvl--) begin
      idx = 32'(vp[IDX_W*lvl +: IDX_W]);
      slot_no = SLOT_W'(frame_no * ENTRIES_PER_TABLE + idx);
      entry = shadow_store[slot_no];
      if (!entry[0]) begin
        if (!make) return ST_NOPATH;
        if (shadow_next_table >= TABLE_FRAMES) return ST_NOFRAME;
        entry = {12'h000, shadow_base_frame + FRAME_W'(shadow_next_table), PTR_FLAGS};
        shadow_store[slot_no] = entry;
        shadow_next_table++;
      end
      ptr_frame = entry[51:12];
      // A pointer below the base or past the store end is treated as a missing path.
      if (ptr_frame < shadow_base_frame) return ST_NOPATH;
      offset = ptr_frame - shadow_base_frame;
      if (offset >= FRAME_W'(TABLE_FRAMES)) return ST_NOPATH;
      frame_no = 32'(offset);
    end
    leaf = SLOT_W'(frame_no * ENTRIES_PER_TABLE + 32'(vp[IDX_W-1:0]));
    return ST_DONE;
  endfunction

  function automatic res_t compute_walk_result(input req_t r);
    res_t               res;
    logic [SLOT_W-1:0]  leaf;
    logic [ENTRY_W-1:0] old_entry;
    res.status = walk_shadow_tables(r.virtual_page, r.command == CMD_MAP, leaf);
    res.entry_value = '0;
    res.tlb_invalidate = 1'b0;
    if (res.status == ST_DONE) begin
      old_entry = shadow_store[leaf];
      res.entry_value = old_entry;
      case (r.command)
        CMD_MAP: begin
          if (old_entry[0]) begin
            res.status = ST_PRESENT;
          end else begin
            res.entry_value = {r.no_execute, 11'b0, r.target_frame, r.attribute_bits};
            shadow_store[leaf] = res.entry_value;
            res.tlb_invalidate = 1'b1;
          end
        end
        CMD_UNMAP: begin
          if (old_entry[0]) begin
            res.entry_value[0] = 1'b0;
            shadow_store[leaf] = res.entry_value;
            res.tlb_invalidate = 1'b1;
          end
        end
        CMD_REMAP: begin
          if (old_entry != '0) begin
            res.entry_value[0] = 1'b1;
            shadow_store[leaf] = res.entry_value;
            res.tlb_invalidate = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Sends one request in bursts with random gaps and records its expected result.
  task automatic send_request(input req_t r, output res_t predicted);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = compute_walk_result(r);
    pending_results.push_back(predicted);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_table_base(input logic [FRAME_W-1:0] value);
    wait_drained();
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_base_frame = value;
  endtask

  task automatic test_basic_commands();
    res_t got;
    send_request(make_req(CMD_MAP, '0, '1, '1, 1'b1), got);
    send_request(make_req(CMD_LOOKUP, '0, '0, '0, 1'b0), got);
    send_request(make_req(CMD_UNMAP, '0, '0, '0, 1'b0), got);
    send_request(make_req(CMD_REMAP, '0, '0, '0, 1'b0), got);
    send_request(make_req(CMD_LOOKUP, '0, '0, '0, 1'b0), got);
    send_request(make_req(CMD_MAP, '1, '0, '0, 1'b0), got);
    send_request(make_req(CMD_LOOKUP, '1, '1, '1, 1'b1), got);
  endtask

  task automatic test_special_cases();
    res_t             got;
    logic [VPAGE_W-1:0] vp;
    // The leaf of the all-ones page is all zero here, so remap leaves it alone.
    send_request(make_req(CMD_REMAP, '1, '0, '0, 1'b0), got);
    send_request(make_req(CMD_UNMAP, '1, '0, '0, 1'b0), got);
    send_request(make_req(CMD_MAP, '1, FRAME_W'(rand64()), 12'h0FE, 1'b1), got);
    send_request(make_req(CMD_REMAP, '1, '0, '0, 1'b0), got);
    send_request(make_req(CMD_REMAP, '1, '0, '0, 1'b0), got);
    send_request(make_req(CMD_MAP, '1, FRAME_W'(rand64()), 12'h001, 1'b0), got);
    vp = {9'h155, 27'(rand64())};
    send_request(make_req(CMD_LOOKUP, vp, '0, '0, 1'b0), got);
    send_request(make_req(CMD_UNMAP, vp, '0, '0, 1'b0), got);
    send_request(make_req(CMD_REMAP, vp, '0, '0, 1'b0), got);
    send_request(make_req(CMD_MAP, 36'h0000001FF, FRAME_W'(rand64()), 12'h003, 1'b0), got);
  endtask

  task automatic test_table_base();
    res_t got;
    write_table_base('1);
    send_request(make_req(CMD_LOOKUP, '0, '0, '0, 1'b0), got);
    send_request(make_req(CMD_MAP, '0, FRAME_W'(rand64()), 12'h001, 1'b0), got);
    send_request(make_req(CMD_MAP, {9'h0AA, 27'd5}, FRAME_W'(rand64()), 12'h001, 1'b0), got);
    write_table_base(FRAME_W'(rand64()));
    send_request(make_req(CMD_LOOKUP, '1, '0, '0, 1'b0), got);
    write_table_base('0);
    send_request(make_req(CMD_LOOKUP, '0, '0, '0, 1'b0), got);
  endtask

  function automatic req_t random_walk_request();
    logic [IDX_W-1:0] leaf_idx;
    logic [1:0]       cmd;
    int unsigned      pick;
    if ($urandom_range(0, 99) < 12) begin
      return make_req(2'($urandom_range(0, 3)), VPAGE_W'(rand64()), FRAME_W'(rand64()),
                      12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    end
    // Most leaves come from a small set so that mapped entries are hit again.
    if ($urandom_range(0, 99) < 80) leaf_idx = 9'($urandom_range(0, 15));
    else leaf_idx = 9'($urandom_range(0, 511));
    pick = $urandom_range(0, 99);
    if (pick < 35) cmd = CMD_MAP;
    else if (pick < 60) cmd = CMD_LOOKUP;
    else if (pick < 80) cmd = CMD_UNMAP;
    else cmd = CMD_REMAP;
    return make_req(cmd, {ws_top[1'($urandom_range(0, 1))], ws_sec[1'($urandom_range(0, 1))],
                          ws_thr[1'($urandom_range(0, 1))], leaf_idx},
                    FRAME_W'(rand64()), 12'($urandom_range(0, 4095)),
                    1'($urandom_range(0, 1)));
  endfunction

  task automatic run_random_batch(input int count);
    res_t got;
    for (int i = 0; i < count; i++) send_request(random_walk_request(), got);
  endtask

  task automatic test_random_walks();
    res_t got;
    for (int i = 0; i < 2; i++) begin
      ws_top[i] = 9'($urandom_range(0, 511));
      ws_sec[i] = 9'($urandom_range(0, 511));
      ws_thr[i] = 9'($urandom_range(0, 511));
    end
    // Build every path of the working set before the pool can run dry.
    for (int p = 0; p < 8; p++) begin
      send_request(make_req(CMD_MAP, {ws_top[p[2]], ws_sec[p[1]], ws_thr[p[0]],
                                      9'($urandom_range(0, 511))},
                            FRAME_W'(rand64()), 12'($urandom_range(0, 4095)),
                            1'($urandom_range(0, 1))),
                   got);
    end
    run_random_batch(650);
    write_table_base('1);
    run_random_batch(120);
    write_table_base(FRAME_W'(rand64()));
    run_random_batch(120);
    write_table_base('0);
    run_random_batch(250);
  endtask

  task automatic test_pool_exhaustion();
    res_t got;
    req_t r;
    int   nofree_seen;
    nofree_seen = 0;
    for (int i = 0; i < 120 && nofree_seen < 3; i++) begin
      r = make_req(CMD_MAP, VPAGE_W'(rand64()), FRAME_W'(rand64()),
                   12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
      send_request(r, got);
      if (got.status == ST_NOFRAME) begin
        nofree_seen++;
        send_request(make_req(CMD_LOOKUP, r.virtual_page, '0, '0, 1'b0), got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result_o.entry_value, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (result_o.status !== oldest_result.status)
          report_mismatch("status", 64'(result_o.status), 64'(oldest_result.status));
        if (result_o.entry_value !== oldest_result.entry_value)
          report_mismatch("entry_value", result_o.entry_value, oldest_result.entry_value);
        if (result_o.tlb_invalidate !== oldest_result.tlb_invalidate)
          report_mismatch("tlb_invalidate", 64'(result_o.tlb_invalidate),
                          64'(oldest_result.tlb_invalidate));
      end
    end
  end

  // The limit covers the store clearing pass after reset.
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_FRAMES * ENTRIES_PER_TABLE; i++) shadow_store[SLOT_W'(i)] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_commands();
    test_special_cases();
    test_table_base();
    test_random_walks();
    test_pool_exhaustion();
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
